// ----- sv/animation_frame_sequencer_defines.svh -----
// Assertion macros shared by the frame sequencer RTL.
`ifndef ANIMATION_FRAME_SEQUENCER_DEFINES_SVH
`define ANIMATION_FRAME_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define AFS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AFS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/afs_pkg.sv -----
// Shared types and constants for the animation frame sequencer.
package afs_pkg;

   localparam int MAX_FRAMES_DEFAULT = 64;
   localparam int FRAME_SLOTS        = 64;

   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int TIME_W  = 16;
   localparam int FRAME_W = 6;
   localparam int COUNT_W = 7;
   localparam int ACC_W   = 18;
   localparam int LIM_W   = 17;

   localparam int TS_LSB  = 0;
   localparam int IDX_LSB = 16;
   localparam int EXT_LSB = 22;

   localparam logic [TIME_W-1:0]  BASE_RESET  = 16'd100;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd1;

   typedef enum logic [1:0] {
      REQ_TICK = 2'd0,
      REQ_PLAY = 2'd1,
      REQ_STOP = 2'd2,
      REQ_LOAD = 2'd3
   } afs_req_type;

   localparam logic [CSR_ADDR_W-1:0] CSR_BASE_DURATION = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_COUNT   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOOP_ENABLE   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_YOYO_ENABLE   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_REVERSE = 3'd4;

   typedef struct packed {
      logic accept;
      logic step;
      logic emit;
   } afs_cmd_type;

   typedef struct packed {
      logic run_ok;
      logic over_limit;
      logic halt;
      logic rsp_free;
   } afs_status_type;

endpackage

// ----- sv/animation_frame_sequencer.sv -----
// Play, stop, load and idle ticks go from the transfer to the emit state, then to the result
// register once the output is free. A running tick makes one fetch/limit/compare pass per limit
// subtraction, plus a last one unless it ends, through the extra-duration table read port.
// One item at a time; the next is taken once the result is in the output register.
// Reset is synchronous: frame 0, stopped, forward, table entries read as zero.
`include "animation_frame_sequencer_defines.svh"

module animation_frame_sequencer #(
   parameter int MAX_FRAMES = afs_pkg::MAX_FRAMES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // timestep[15:0], frame_index[21:16], extra_duration[37:22], zero pad
   input  logic [afs_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  logic [afs_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // frame_number[5:0], playing[6], reversing[7], finished[8], zero pad
   output logic [afs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [afs_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [afs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import afs_pkg::*;

   afs_req_type    req_kind;
   afs_cmd_type    cmd;
   afs_status_type status;

   assign req_kind = afs_req_type'(req_tuser);

   afs_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_kind),
      .status     (status),
      .cmd        (cmd)
   );

   afs_datapath #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_kind   (req_kind),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `AFS_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready, "second transfer taken")
   `AFS_ASSERT_SAME(a_emit_free, cmd.emit, !rsp_tvalid || rsp_tready, "result overwritten")
   `AFS_ASSERT_SAME(a_done_stops, rsp_tvalid, !(rsp_tdata[8] && rsp_tdata[6]), "finished while playing")
   `AFS_ASSERT_NEXT(a_emit_valid, cmd.emit, rsp_tvalid, "emit lost")

endmodule

// ----- sv/afs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module afs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/afs_controller.sv -----
// Control state machine: accept, per-frame fetch/limit/step loop, result emit.
module afs_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  afs_pkg::afs_req_type   req_kind,
   input  afs_pkg::afs_status_type status,
   output afs_pkg::afs_cmd_type   cmd
);
   import afs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_LIMIT,
      S_STEP,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      xfer;

   assign xfer = req_tvalid && (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (xfer) begin
               state_in = (req_kind == REQ_TICK && status.run_ok) ? S_FETCH : S_EMIT;
            end
         end
         S_FETCH: state_in = S_LIMIT;
         S_LIMIT: state_in = S_STEP;
         S_STEP: begin
            state_in = (!status.over_limit || status.halt) ? S_EMIT : S_FETCH;
         end
         S_EMIT: begin
            if (status.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign cmd.accept = xfer;
   assign cmd.step   = (state_ff == S_STEP);
   assign cmd.emit   = (state_ff == S_EMIT) && status.rsp_free;

endmodule

// ----- sv/afs_datapath.sv -----
// Datapath: config registers, frame state, extra-duration table, result register.
module afs_datapath #(
   parameter int MAX_FRAMES = afs_pkg::MAX_FRAMES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [afs_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  afs_pkg::afs_req_type              req_kind,
   input  logic                              csr_we,
   input  logic [afs_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [afs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  afs_pkg::afs_cmd_type              cmd,
   output afs_pkg::afs_status_type           status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [afs_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import afs_pkg::*;

   localparam int TABLE_DEPTH = (MAX_FRAMES < FRAME_SLOTS) ? MAX_FRAMES : FRAME_SLOTS;
   localparam int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CAP         = (MAX_FRAMES < 128) ? MAX_FRAMES : 128;
   localparam logic [COUNT_W-1:0] TABLE_DEPTH_W = COUNT_W'(TABLE_DEPTH);
   localparam logic [COUNT_W:0]   CAP_W         = (COUNT_W + 1)'(CAP);

   logic [TIME_W-1:0]  timestep;
   logic [FRAME_W-1:0] frame_index;
   logic [TIME_W-1:0]  extra_duration;

   assign timestep       = req_tdata[TS_LSB  +: TIME_W];
   assign frame_index    = req_tdata[IDX_LSB +: FRAME_W];
   assign extra_duration = req_tdata[EXT_LSB +: TIME_W];

   logic [TIME_W-1:0]      base_ff, base_in;
   logic [COUNT_W-1:0]     fcount_ff, fcount_in;
   logic                   loop_ff, loop_in;
   logic                   yoyo_ff, yoyo_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [FRAME_W-1:0]     frame_ff, frame_in;
   logic                   rev_ff, rev_in;
   logic                   at_end_ff, at_end_in;
   logic                   play_ff, play_in;
   logic                   done_ff, done_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic                   ext_vld_ff;
   logic [LIM_W-1:0]       lim_ff, lim_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                   load_we;
   logic [TIME_W-1:0]      ram_rdata;
   logic [COUNT_W:0]       count_n;
   logic [COUNT_W-1:0]     last;
   logic [FRAME_W-1:0]     prev_frame;
   logic [COUNT_W-1:0]     next_frame;
   logic [FRAME_W-1:0]     step_frame;
   logic [LIM_W-1:0]       lim_sum;
   logic                   over;

   assign load_we = cmd.accept && (req_kind == REQ_LOAD)
                    && ({1'b0, frame_index} < TABLE_DEPTH_W);

   afs_ram #(
      .WIDTH (TIME_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (load_we),
      .waddr (frame_index[AW-1:0]),
      .wdata (extra_duration),
      .raddr (frame_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   // last frame index from the clamped frame count
   always_comb begin
      count_n = (fcount_ff == '0) ? (COUNT_W + 1)'(1) : {1'b0, fcount_ff};
      if (count_n > CAP_W) begin
         count_n = CAP_W;
      end
      last = COUNT_W'(count_n - (COUNT_W + 1)'(1));
   end

   always_comb begin
      lim_sum = {1'b0, base_ff} + {1'b0, (ext_vld_ff ? ram_rdata : '0)};
      lim_in  = (lim_sum == '0) ? LIM_W'(1) : lim_sum;
   end

   assign over = (acc_ff >= {1'b0, lim_ff});

   // one frame step in the current direction, clamped to 0..last
   always_comb begin
      if (rev_ff) begin
         prev_frame = (frame_ff == '0) ? '0 : frame_ff - FRAME_W'(1);
         step_frame = ({1'b0, prev_frame} > last) ? last[FRAME_W-1:0] : prev_frame;
         next_frame = '0;
      end else begin
         next_frame = ({1'b0, frame_ff} >= last) ? last : {1'b0, frame_ff} + COUNT_W'(1);
         prev_frame = '0;
         step_frame = next_frame[FRAME_W-1:0];
      end
   end

   always_comb begin
      base_in      = base_ff;
      fcount_in    = fcount_ff;
      loop_in      = loop_ff;
      yoyo_in      = yoyo_ff;
      acc_in       = acc_ff;
      frame_in     = frame_ff;
      rev_in       = rev_ff;
      at_end_in    = at_end_ff;
      play_in      = play_ff;
      done_in      = done_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         case (csr_addr)
            CSR_BASE_DURATION: base_in   = csr_wdata;
            CSR_FRAME_COUNT:   fcount_in = csr_wdata[COUNT_W-1:0];
            CSR_LOOP_ENABLE:   loop_in   = csr_wdata[0];
            CSR_YOYO_ENABLE:   yoyo_in   = csr_wdata[0];
            CSR_START_REVERSE: rev_in    = csr_wdata[0];
            default: ;
         endcase
      end

      if (cmd.accept) begin
         case (req_kind)
            REQ_TICK: begin
               if (play_ff && !done_ff) begin
                  acc_in = acc_ff + {2'b0, timestep};
               end
            end
            REQ_PLAY: begin
               if (done_ff) begin
                  done_in   = 1'b0;
                  at_end_in = 1'b0;
                  acc_in    = '0;
                  frame_in  = '0;
               end
               play_in = 1'b1;
            end
            REQ_STOP: play_in = 1'b0;
            REQ_LOAD: begin
               if (load_we) begin
                  valid_in[frame_index[AW-1:0]] = 1'b1;
               end
            end
            default: ;
         endcase
      end

      if (cmd.step && over) begin
         acc_in = acc_ff - {1'b0, lim_ff};
         if (at_end_ff) begin
            if (yoyo_ff) begin
               rev_in    = !rev_ff;
               at_end_in = 1'b0;
            end else if (loop_ff) begin
               frame_in  = rev_ff ? last[FRAME_W-1:0] : '0;
               at_end_in = 1'b0;
            end else begin
               done_in = 1'b1;
               play_in = 1'b0;
            end
         end else begin
            frame_in  = step_frame;
            at_end_in = (step_frame == '0) || ({1'b0, step_frame} == last);
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'b0, done_ff, rev_ff, play_ff, frame_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= BASE_RESET;
         fcount_ff    <= COUNT_RESET;
         loop_ff      <= 1'b0;
         yoyo_ff      <= 1'b0;
         acc_ff       <= '0;
         frame_ff     <= '0;
         rev_ff       <= 1'b0;
         at_end_ff    <= 1'b0;
         play_ff      <= 1'b0;
         done_ff      <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         fcount_ff    <= fcount_in;
         loop_ff      <= loop_in;
         yoyo_ff      <= yoyo_in;
         acc_ff       <= acc_in;
         frame_ff     <= frame_in;
         rev_ff       <= rev_in;
         at_end_ff    <= at_end_in;
         play_ff      <= play_in;
         done_ff      <= done_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: table hit flag follows the read address, limit follows read data
   always_ff @(posedge clock) begin
      ext_vld_ff  <= ({1'b0, frame_ff} < TABLE_DEPTH_W) && valid_ff[frame_ff[AW-1:0]];
      lim_ff      <= lim_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.run_ok     = play_ff && !done_ff;
   assign status.over_limit = over;
   assign status.halt       = at_end_ff && !yoyo_ff && !loop_ff;
   assign status.rsp_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
